[rtl/core/ternary_weight_dot_product_defines.svh]
// ----------------------------------------------------------------------------
// Ternary weight dot product: assertion macros
// Shared macros for the concurrent checks of the dot product block.
// ----------------------------------------------------------------------------
`ifndef TERNARY_WEIGHT_DOT_PRODUCT_DEFINES_SVH
`define TERNARY_WEIGHT_DOT_PRODUCT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TWD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define TWD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/twd_pkg.sv]
// ----------------------------------------------------------------------------
// Ternary weight dot product package
// Widths, weight codes and inter-module control types.
// ----------------------------------------------------------------------------
`default_nettype none

package twd_pkg;

    localparam int LANES  = 4;
    localparam int CODE_W = 2;
    localparam int ACT_W  = 8;
    localparam int TERM_W = ACT_W + 1;
    localparam int SUM_W  = 32;
    localparam int LV_W   = 3;

    typedef enum logic [CODE_W-1:0] {
        CODE_ZERO = 2'b00,
        CODE_POS  = 2'b01,
        CODE_NEG  = 2'b10,
        CODE_NIL  = 2'b11
    } t_code;

    typedef logic signed [TERM_W-1:0] t_term;

    typedef struct packed {
        logic go;
        logic last;
    } t_merge_ctl;

    typedef struct packed {
        logic out_free;
    } t_merge_stat;

endpackage

`default_nettype wire

[rtl/core/twd_if.sv]
// ----------------------------------------------------------------------------
// Ternary weight dot product channels
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface twd_in_if;
    logic              valid;
    logic              ready;
    logic [7:0]        weight_byte;
    logic signed [7:0] act0;
    logic signed [7:0] act1;
    logic signed [7:0] act2;
    logic signed [7:0] act3;
    logic [2:0]        lanes_valid;
    logic              last;

    modport source (
        output valid, weight_byte, act0, act1, act2, act3, lanes_valid, last,
        input  ready
    );
    modport sink (
        input  valid, weight_byte, act0, act1, act2, act3, lanes_valid, last,
        output ready
    );
endinterface

interface twd_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] dot_sum;

    modport source (output valid, dot_sum, input ready);
    modport sink (input valid, dot_sum, output ready);
endinterface

`default_nettype wire

[rtl/core/twd_lane.sv]
// ----------------------------------------------------------------------------
// Ternary weight lane
// Applies one 2-bit ternary code to one activation and registers the term.
// ----------------------------------------------------------------------------
`default_nettype none

module twd_lane (
    input  wire logic                             i_clk,
    input  wire logic                             i_load,
    input  wire logic [twd_pkg::CODE_W-1:0]       i_code,
    input  wire logic signed [twd_pkg::ACT_W-1:0] i_act,
    input  wire logic                             i_en,
    output twd_pkg::t_term                        o_term
);

    twd_pkg::t_term r_term;
    twd_pkg::t_term n_term;

    always_comb begin
        n_term = '0;
        if (i_en) begin
            case (twd_pkg::t_code'(i_code))
                twd_pkg::CODE_POS: n_term = twd_pkg::TERM_W'(i_act);
                twd_pkg::CODE_NEG: n_term = -twd_pkg::TERM_W'(i_act);
                default:           n_term = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_term <= n_term;
        end
    end

    assign o_term = r_term;

endmodule

`default_nettype wire

[rtl/core/twd_merge.sv]
// ----------------------------------------------------------------------------
// Ternary weight merge stage
// Adds the lane terms into the running sum and holds the finished result.
// ----------------------------------------------------------------------------
`default_nettype none

module twd_merge (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire twd_pkg::t_merge_ctl   i_ctl,
    input  wire twd_pkg::t_term        i_terms [twd_pkg::LANES],
    output twd_pkg::t_merge_stat       o_stat,
    twd_out_if.source                  o_out
);

    logic signed [twd_pkg::SUM_W-1:0] r_acc;
    logic signed [twd_pkg::SUM_W-1:0] r_out_sum;
    logic                             r_out_valid;
    logic signed [twd_pkg::SUM_W-1:0] n_tree;
    logic signed [twd_pkg::SUM_W-1:0] n_total;

    always_comb begin
        n_tree = '0;
        for (int k = 0; k < twd_pkg::LANES; k++) begin
            n_tree = n_tree + twd_pkg::SUM_W'(i_terms[k]);
        end
        n_total = r_acc + n_tree;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.go) begin
                r_acc <= i_ctl.last ? '0 : n_total;
            end
            if (i_ctl.go && i_ctl.last) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.go && i_ctl.last) begin
            r_out_sum <= n_total;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.dot_sum   = r_out_sum;
    assign o_stat.out_free = !r_out_valid || o_out.ready;

endmodule

`default_nettype wire

[rtl/core/ternary_weight_dot_product.sv]
// ----------------------------------------------------------------------------
// Ternary weight dot product
// Int8 activations times packed ternary weights, accumulated per row.
// ----------------------------------------------------------------------------
// Each input word carries four activations and a byte of four 2-bit weight
// codes; four lanes weigh them in parallel, a merge stage adds the lane terms
// into a 32-bit wrapping running sum, and a word with last set emits the sum
// and clears it. The block takes one word per cycle unless stalled; a result
// appears once the last word of its row has passed the lane register and then
// the result register. A waiting result stalls input only when another row end
// reaches the merge stage before the result is taken.
`default_nettype none
`include "ternary_weight_dot_product_defines.svh"

module ternary_weight_dot_product (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    twd_in_if.sink    i_in,
    twd_out_if.source o_out
);

    logic                      r_s1_valid;
    logic                      r_s1_last;
    logic                      s1_go;
    logic                      load;
    logic signed [twd_pkg::ACT_W-1:0] acts [twd_pkg::LANES];
    twd_pkg::t_term            terms [twd_pkg::LANES];
    twd_pkg::t_merge_ctl       merge_ctl;
    twd_pkg::t_merge_stat      merge_stat;

    assign acts[0] = i_in.act0;
    assign acts[1] = i_in.act1;
    assign acts[2] = i_in.act2;
    assign acts[3] = i_in.act3;

    assign s1_go      = r_s1_valid && (!r_s1_last || merge_stat.out_free);
    assign i_in.ready = !r_s1_valid || s1_go;
    assign load       = i_in.valid && i_in.ready;

    assign merge_ctl.go   = s1_go;
    assign merge_ctl.last = r_s1_last;

    for (genvar k = 0; k < twd_pkg::LANES; k++) begin : g_lane
        twd_lane u_lane (
            .i_clk  (i_clk),
            .i_load (load),
            .i_code (i_in.weight_byte[twd_pkg::CODE_W*k +: twd_pkg::CODE_W]),
            .i_act  (acts[k]),
            .i_en   (i_in.lanes_valid > twd_pkg::LV_W'(k)),
            .o_term (terms[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (load) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_s1_last <= i_in.last;
        end
    end

    twd_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (merge_ctl),
        .i_terms (terms),
        .o_stat  (merge_stat),
        .o_out   (o_out)
    );

    `TWD_ASSERT_NOW(a_stall_on_full_result, i_clk, i_rst_n, r_s1_valid && r_s1_last && o_out.valid && !o_out.ready, !i_in.ready, "row end accepted input while result was blocked")
    `TWD_ASSERT_NEXT(a_load_fills_stage, i_clk, i_rst_n, i_in.valid && i_in.ready, r_s1_valid, "accepted word did not reach the lane stage")
    `TWD_ASSERT_NOW(a_result_from_row_end, i_clk, i_rst_n, $rose(o_out.valid), $past(s1_go && r_s1_last), "result appeared without a row end")

endmodule

`default_nettype wire

[test/testbench.sv]
// ----------------------------------------------------------------------------
// Ternary weight dot product testbench
// Streams packed ternary weights and int8 activations into the block. A
// short directed section covers the weight codes, the activation extremes and
// every lane count. Random rows follow, with idle cycles on both channels.
// Every finished sum is checked against an independent running prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORD_TARGET = 1350;

    class dot_sum_board;
        logic signed [twd_pkg::SUM_W-1:0] partial_sum;
        logic signed [twd_pkg::SUM_W-1:0] pending_sums[$];
        int words;
        int sums_checked;
        int zero_lane_words;
        int mismatches;

        function new();
            partial_sum = '0;
            words = 0;
            sums_checked = 0;
            zero_lane_words = 0;
            mismatches = 0;
        endfunction

        function void note_word(logic [7:0] wb,
                                logic [twd_pkg::LANES*twd_pkg::ACT_W-1:0] act_bus,
                                logic [twd_pkg::LV_W-1:0] lanes, logic lst);
            logic signed [twd_pkg::SUM_W-1:0] sum;
            logic signed [twd_pkg::ACT_W-1:0] act;
            sum = partial_sum;
            for (int i = 0; i < twd_pkg::LANES; i++) begin
                if (i < lanes) begin
                    act = act_bus[i*twd_pkg::ACT_W +: twd_pkg::ACT_W];
                    case (twd_pkg::t_code'(wb[i*twd_pkg::CODE_W +: twd_pkg::CODE_W]))
                        twd_pkg::CODE_POS: sum = sum + twd_pkg::SUM_W'(act);
                        twd_pkg::CODE_NEG: sum = sum - twd_pkg::SUM_W'(act);
                        default: ;
                    endcase
                end
            end
            words++;
            if (lanes == 0)
                zero_lane_words++;
            if (lst) begin
                pending_sums.push_back(sum);
                partial_sum = '0;
            end else begin
                partial_sum = sum;
            end
        endfunction

        function void check_sum(logic signed [twd_pkg::SUM_W-1:0] actual);
            logic signed [twd_pkg::SUM_W-1:0] expected;
            if (pending_sums.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("dot_sum %0d arrived with no sum outstanding", actual);
                return;
            end
            expected = pending_sums.pop_front();
            sums_checked++;
            if (actual !== expected) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("dot_sum mismatch: expected %0d, got %0d", expected, actual);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic calm;

    twd_in_if  in_ch();
    twd_out_if out_ch();

    dot_sum_board board = new();

    ternary_weight_dot_product dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready)
                board.check_sum(out_ch.dot_sum);
            out_ch.ready <= calm || ($urandom_range(99) >= 29);
        end
    end

    function automatic logic [twd_pkg::ACT_W-1:0] pick_act();
        case ($urandom_range(7))
            0: return 8'h80;
            1: return 8'h7F;
            2: return 8'hFF;
            default: return twd_pkg::ACT_W'($urandom);
        endcase
    endfunction

    task automatic send_word(logic [7:0] wb, logic [twd_pkg::ACT_W-1:0] a0,
                             logic [twd_pkg::ACT_W-1:0] a1,
                             logic [twd_pkg::ACT_W-1:0] a2,
                             logic [twd_pkg::ACT_W-1:0] a3,
                             logic [twd_pkg::LV_W-1:0] lanes, logic lst);
        int gap;
        gap = 0;
        if (!calm) begin
            while ($urandom_range(99) < 29)
                gap++;
        end
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.weight_byte <= wb;
        in_ch.act0        <= a0;
        in_ch.act1        <= a1;
        in_ch.act2        <= a2;
        in_ch.act3        <= a3;
        in_ch.lanes_valid <= lanes;
        in_ch.last        <= lst;
        do
            @(posedge i_clk);
        while (!in_ch.ready);
        board.note_word(wb, {a3, a2, a1, a0}, lanes, lst);
    endtask

    task automatic send_row(int len, logic noisy);
        logic [twd_pkg::LV_W-1:0] lanes;
        for (int k = 0; k < len; k++) begin
            if (noisy || k == len - 1)
                lanes = twd_pkg::LV_W'($urandom_range(7));
            else
                lanes = twd_pkg::LV_W'(twd_pkg::LANES);
            send_word(8'($urandom), pick_act(), pick_act(), pick_act(), pick_act(),
                      lanes, k == len - 1);
        end
    endtask

    task automatic wait_for_sums();
        in_ch.valid <= 1'b0;
        while (board.pending_sums.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        int len;
        logic paused;
        calm = 1'b0;
        paused = 1'b0;
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.weight_byte <= '0;
        in_ch.act0        <= '0;
        in_ch.act1        <= '0;
        in_ch.act2        <= '0;
        in_ch.act3        <= '0;
        in_ch.lanes_valid <= '0;
        in_ch.last        <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_word(8'h55, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 3'd4, 1'b0);
        send_word(8'h55, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 3'd4, 1'b1);
        send_word(8'hAA, 8'h80, 8'h80, 8'h80, 8'h80, 3'd4, 1'b1);
        send_word(8'h55, 8'h80, 8'h80, 8'h80, 8'h80, 3'd4, 1'b1);
        send_word(8'hAA, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 3'd4, 1'b1);
        send_word(8'hFF, 8'h7F, 8'h80, 8'h01, 8'hFF, 3'd4, 1'b1);
        send_word(8'h00, 8'h7F, 8'h80, 8'h01, 8'hFF, 3'd4, 1'b1);
        send_word(8'hE4, 8'h11, 8'h22, 8'h33, 8'h44, 3'd4, 1'b1);
        send_word(8'h55, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 3'd0, 1'b0);
        send_word(8'h55, 8'h05, 8'h7F, 8'h7F, 8'h7F, 3'd1, 1'b0);
        send_word(8'h55, 8'h06, 8'h07, 8'h7F, 8'h7F, 3'd2, 1'b0);
        send_word(8'h55, 8'h08, 8'h09, 8'h0A, 8'h7F, 3'd3, 1'b0);
        send_word(8'h55, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 3'd0, 1'b1);
        send_word(8'hAA, 8'h80, 8'h80, 8'h80, 8'h80, 3'd0, 1'b1);
        send_word(8'h99, 8'h80, 8'h7F, 8'h80, 8'h7F, 3'd5, 1'b0);
        send_word(8'h66, 8'h80, 8'h7F, 8'h80, 8'h7F, 3'd6, 1'b0);
        send_word(8'h5A, 8'hC3, 8'h3C, 8'hFF, 8'h01, 3'd7, 1'b1);
        send_word(8'h1B, 8'h80, 8'h80, 8'h80, 8'h80, 3'd3, 1'b1);
        send_word(8'hB1, 8'h7F, 8'h80, 8'h7F, 8'h80, 3'd2, 1'b1);
        send_word(8'h6C, 8'h01, 8'hFF, 8'h80, 8'h7F, 3'd1, 1'b1);

        wait_for_sums();

        while (board.words < WORD_TARGET) begin
            calm = board.words >= 500 && board.words < 800;
            if ($urandom_range(19) == 0)
                len = $urandom_range(40, 16);
            else
                len = $urandom_range(12, 1);
            send_row(len, $urandom_range(99) < 15);
            if (!paused && board.words >= 1000) begin
                paused = 1'b1;
                wait_for_sums();
            end
        end
        calm = 1'b0;
        in_ch.valid <= 1'b0;

        wait_for_sums();
        repeat (8) @(posedge i_clk);

        $display("Checked %0d dot products built from %0d words, %0d of them with no lanes.",
                 board.sums_checked, board.words, board.zero_lane_words);
        $display("Mismatches: %0d, sums still outstanding: %0d.",
                 board.mismatches, board.pending_sums.size());
        if (board.mismatches == 0 && board.pending_sums.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
